FILE: sv/sfd_pkg.sv
// Package for the sync-word frame deframer: constants, result record,
// register indexes and the CRC-16 byte update. No dependencies.
package sfd_pkg;

	localparam int unsigned DEF_MAX_PAYLOAD  = 32;
	localparam int unsigned DEF_BUFFER_BYTES = 41;
	localparam int unsigned QUEUE_DEPTH      = 4;

	localparam int unsigned HDR_BYTES = 7;
	localparam int unsigned CRC_BYTES = 2;

	// header byte offsets from the first sync byte
	localparam int unsigned OFS_VER  = 2;
	localparam int unsigned OFS_TYPE = 3;
	localparam int unsigned OFS_SLOT = 4;
	localparam int unsigned OFS_SEQ  = 5;
	localparam int unsigned OFS_LEN  = 6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	// configuration register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_PAYLOAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic       last;
		kind_t      kind;
		logic [5:0] length;
		logic [7:0] seq;
		logic [7:0] slot;
		logic [7:0] ftype;
		logic [7:0] version;
		logic [7:0] data;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

	// CRC-16, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/sync_frame_deframer_crc16_unit.sv
// Top level of the sync-word frame deframer with CRC-16 check.
// Depends on sfd_pkg, sfd_fifo and sfd_scan.
//
// Received bytes come in on the s_ side and go through a short input queue to
// a scanner that keeps unresolved bytes in a circular hold memory with one
// read port; results leave through a short output queue on the m_ side, so
// both sides can stall on their own. The scanner takes a byte only while idle,
// then examines the held bytes with one memory read per byte examined and
// releases those that start no frame as text. A final check and an end state
// follow. A byte that completes a frame adds a CRC pass over the memory and
// the payload read-out. A failed length or CRC check rescans the held bytes
// from the next one. The scanner takes no new byte until the last one is
// through. Results of one input byte end with m_tlast set. No clearing pass.
module sync_frame_deframer_crc16_unit import sfd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
	parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte, frame_version, frame_type, frame_slot, frame_seq, frame_length, pad
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast
);

	logic       q_valid, q_ready;
	logic [7:0] q_byte;
	logic       r_valid, r_ready;
	result_t    r_res, o_res;
	logic [RESULT_W-1:0] o_bits;

	// input queue
	sfd_fifo #(.W(8), .DEPTH(QUEUE_DEPTH)) u_in_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_byte)
	);

	// scanner
	sfd_scan #(.MAX_PAYLOAD(MAX_PAYLOAD), .BUFFER_BYTES(BUFFER_BYTES)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_byte   (q_byte),
		.res_valid (r_valid),
		.res_ready (r_ready),
		.res       (r_res)
	);

	// output queue
	sfd_fifo #(.W(RESULT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_ready  (r_ready),
		.in_data   (r_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (o_bits)
	);

	assign o_res   = result_t'(o_bits);
	assign m_tdata = {2'b00, o_res.length, o_res.seq, o_res.slot,
	                  o_res.ftype, o_res.version, o_res.data};
	assign m_tuser = o_res.kind;
	assign m_tlast = o_res.last;

endmodule

FILE: sv/sfd_fifo.sv
// Small first-in first-out queue with valid/ready on both sides.
// Used between the input side, the scanner and the output side; no package use.
module sfd_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != NW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = slot_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_data;
		end
	end

endmodule

FILE: sv/sfd_scan.sv
// Scanner: holds unresolved bytes in a circular memory and resolves text,
// frame headers and payload one byte per memory read. Depends on sfd_pkg.
module sfd_scan import sfd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD  = DEF_MAX_PAYLOAD,
	parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	localparam int unsigned AW = $clog2(BUFFER_BYTES);
	localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned SW = AW + 1;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_CHK  = 12'b000000000010,
		S_B0   = 12'b000000000100,
		S_B1   = 12'b000000001000,
		S_TXT  = 12'b000000010000,
		S_LEN  = 12'b000000100000,
		S_CRC  = 12'b000001000000,
		S_CLO  = 12'b000010000000,
		S_CHI  = 12'b000100000000,
		S_HDR  = 12'b001000000000,
		S_PAY  = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [7:0]    mem [BUFFER_BYTES];
	logic [7:0]    rdata_q;
	logic [7:0]    b0_q, lo_q, ver_q, type_q, slot_q, seq_q;
	logic [7:0]    sf_q, ss_q;
	logic [5:0]    plen_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   crc_q;
	result_t       pend_q;
	logic          pend_v_q;

	logic          want_gen, fire, accept;
	result_t       gen_res;
	logic [AW-1:0] rd_off, rd_addr, tail_addr, pay_base, last_idx;
	logic [SW-1:0] rd_sum, tail_sum, head_sum;
	logic          pop_en;
	logic [CW-1:0] pop_k;
	logic [8:0]    total9;
	logic          len_ok;

	assign pay_base = AW'(HDR_BYTES) + AW'(plen_q);
	assign last_idx = AW'(HDR_BYTES - 1) + AW'(plen_q);
	assign total9   = 9'(rdata_q) + 9'(HDR_BYTES + CRC_BYTES);
	assign len_ok   = (9'(rdata_q) <= 9'(MAX_PAYLOAD));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// result hand-off through a one-deep pending slot so the step's final
	// result can be marked once the step is known to be over
	assign want_gen  = (state_q == S_TXT) || (state_q == S_HDR) || (state_q == S_PAY);
	assign fire      = want_gen && (!pend_v_q || res_ready);
	assign res_valid = pend_v_q && (want_gen || (state_q == S_DONE));
	always_comb begin
		res      = pend_q;
		res.last = (state_q == S_DONE);
	end

	// result built in the current state
	always_comb begin
		gen_res      = '0;
		gen_res.kind = KIND_TEXT;
		case (state_q)
			S_TXT: begin
				gen_res.data = b0_q;
			end
			S_HDR: begin
				gen_res.kind    = KIND_HEADER;
				gen_res.version = ver_q;
				gen_res.ftype   = type_q;
				gen_res.slot    = slot_q;
				gen_res.seq     = seq_q;
				gen_res.length  = plen_q;
			end
			S_PAY: begin
				gen_res.kind = KIND_PAYLOAD;
				gen_res.data = rdata_q;
			end
			default: begin
				gen_res.kind = KIND_TEXT;
			end
		endcase
	end

	// next state, read offset and byte release
	always_comb begin
		state_d = state_q;
		rd_off  = '0;
		pop_en  = 1'b0;
		pop_k   = CW'(1);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = (count_q == '0) ? S_DONE : S_B0;
			end
			S_B0: begin
				rd_off = AW'(1);
				if (count_q == CW'(1)) begin
					state_d = (rdata_q == sf_q) ? S_DONE : S_TXT;
				end else begin
					state_d = S_B1;
				end
			end
			S_B1: begin
				rd_off = AW'(OFS_LEN);
				if (b0_q == sf_q && rdata_q == ss_q) begin
					state_d = (count_q < CW'(HDR_BYTES)) ? S_DONE : S_LEN;
				end else begin
					state_d = S_TXT;
				end
			end
			S_TXT: begin
				if (fire) begin
					pop_en  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_LEN: begin
				if (!len_ok) begin
					pop_en  = 1'b1;
					state_d = S_CHK;
				end else if (9'(count_q) < total9) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CRC;
				end
			end
			S_CRC: begin
				if (idx_q == last_idx) begin
					rd_off  = pay_base;
					state_d = S_CLO;
				end else begin
					rd_off = idx_q + 1'b1;
				end
			end
			S_CLO: begin
				rd_off  = pay_base + 1'b1;
				state_d = S_CHI;
			end
			S_CHI: begin
				rd_off = AW'(HDR_BYTES);
				if ({rdata_q, lo_q} == crc_q) begin
					state_d = S_HDR;
				end else begin
					pop_en  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_HDR: begin
				rd_off = AW'(HDR_BYTES);
				if (fire) begin
					if (plen_q == '0) begin
						pop_en  = 1'b1;
						pop_k   = CW'(HDR_BYTES + CRC_BYTES);
						state_d = S_CHK;
					end else begin
						state_d = S_PAY;
					end
				end
			end
			S_PAY: begin
				rd_off = AW'(HDR_BYTES) + idx_q;
				if (fire) begin
					rd_off = AW'(HDR_BYTES) + idx_q + 1'b1;
					if (idx_q == AW'(plen_q - 6'd1)) begin
						pop_en  = 1'b1;
						pop_k   = CW'(plen_q) + CW'(HDR_BYTES + CRC_BYTES);
						state_d = S_CHK;
					end
				end
			end
			S_DONE: begin
				if (!pend_v_q || res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// circular addressing of the hold memory
	assign rd_sum    = SW'(head_q) + SW'(rd_off);
	assign rd_addr   = (rd_sum >= SW'(BUFFER_BYTES)) ? AW'(rd_sum - SW'(BUFFER_BYTES))
	                                                 : AW'(rd_sum);
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= SW'(BUFFER_BYTES)) ? AW'(tail_sum - SW'(BUFFER_BYTES))
	                                                   : AW'(tail_sum);
	assign head_sum  = SW'(head_q) + SW'(pop_k);

	// hold memory: write on transfer, registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[tail_addr] <= in_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
			sf_q     <= SYNC_FIRST_RST;
			ss_q     <= SYNC_SECOND_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_SYNC_FIRST) begin
					sf_q <= cfg_data;
				end
				if (cfg_index == REG_SYNC_SECOND) begin
					ss_q <= cfg_data;
				end
			end
			if (accept) begin
				count_q <= count_q + 1'b1;
			end else if (pop_en) begin
				count_q <= count_q - pop_k;
				head_q  <= (head_sum >= SW'(BUFFER_BYTES))
				           ? AW'(head_sum - SW'(BUFFER_BYTES)) : AW'(head_sum);
			end
			if (fire) begin
				pend_v_q <= 1'b1;
			end else if (state_q == S_DONE && res_ready) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// working registers of the frame check
	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q <= gen_res;
		end
		if (state_q == S_B0) begin
			b0_q <= rdata_q;
		end
		if (state_q == S_LEN) begin
			plen_q <= rdata_q[5:0];
			crc_q  <= CRC_INIT;
			idx_q  <= '0;
		end
		if (state_q == S_CRC) begin
			crc_q <= crc16_byte(crc_q, rdata_q);
			idx_q <= idx_q + 1'b1;
			if (idx_q == AW'(OFS_VER))  ver_q  <= rdata_q;
			if (idx_q == AW'(OFS_TYPE)) type_q <= rdata_q;
			if (idx_q == AW'(OFS_SLOT)) slot_q <= rdata_q;
			if (idx_q == AW'(OFS_SEQ))  seq_q  <= rdata_q;
		end
		if (state_q == S_CLO) begin
			lo_q <= rdata_q;
		end
		if (state_q == S_HDR) begin
			idx_q <= '0;
		end
		if (state_q == S_PAY && fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(BUFFER_BYTES))
		else $error("hold count beyond buffer size");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < BUFFER_BYTES)
		else $error("head pointer out of range");
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |-> (state_q == S_DONE))
		else $error("last result outside end of step");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending result left at idle");
`endif

endmodule
